>>> rtl/quoted_printable_decoder_assert.svh
// Assertion macros for the quoted-printable decoder.
// Included by the top level; the bodies drop out when SYNTH is defined.
`ifndef QUOTED_PRINTABLE_DECODER_ASSERT_SVH
`define QUOTED_PRINTABLE_DECODER_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define QPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("qpd assertion failed");
// next-cycle implication
`define QPD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("qpd assertion failed");
`else
`define QPD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define QPD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/qpd_pkg.sv
// Shared types and constants for the quoted-printable decoder.
// No dependencies; the top level, front end, queue and back end import it.
package qpd_pkg;

	localparam int QPD_MAX_WS  = 16;
	localparam int QPD_Q_DEPTH = 4;

	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_EQ  = 8'h3D;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_US  = 8'h5F;

	// one character for the escape stage; fin marks the last one of the text
	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
	} qpd_tok_t;

	typedef struct packed {
		logic [7:0] data;
		logic       empty;
		logic       last;
	} qpd_res_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_FLUSH,
		F_FLUSH_CR,
		F_ITEM,
		F_DROP_CR,
		F_DROP_LF
	} qpd_fstate_t;

endpackage

>>> rtl/qpd_stream_if.sv
// Valid/ready stream interfaces for the decoder input and output channels.
// Standalone; no package needed.
interface qpd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, in_byte, in_last, input ready);
	modport sink (input valid, in_byte, in_last, output ready);
endinterface

interface qpd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_empty;
	logic       out_last;

	modport source (output valid, out_byte, out_empty, out_last, input ready);
	modport sink (input valid, out_byte, out_empty, out_last, output ready);
endinterface

>>> rtl/quoted_printable_decoder.sv
// Quoted-printable decoder top level: front end, token queue, back end, config register.
// Uses qpd_pkg, qpd_stream_if, qpd_front, qpd_fifo, qpd_back and the assertion header.
//
// in_ch carries one encoded byte per beat, in_last on the final byte of a text.
// out_ch carries decoded bytes; the final beat of a text has out_last set, and a
// text whose last byte decodes to nothing ends with a terminator beat (out_empty,
// out_byte zero). cfg_we/cfg_wdata write the underscore-as-space mode bit; write
// it only between texts.
// Throughput: one input beat per cycle for ordinary text while the token queue has
// room. A byte that ends a held space/tab run blocks in_ch while the run is replayed,
// then any held CR, then the byte itself. An LF that drops a run with its CR blocks
// in_ch while CR and LF go on. A byte that releases a held "=" sequence yields up
// to three output beats, one per cycle at the output register while out_ch is ready.
// With the queue empty and the output free, the first result of a beat is registered
// in the token queue and then in the output register.
// Reset clears the held text flags and counts and the mode bit. When out_ch stalls, the output
// register holds, the four-entry token queue fills and in_ch.ready then drops.
`include "quoted_printable_decoder_assert.svh"
module quoted_printable_decoder #(
	parameter int MAX_WS = qpd_pkg::QPD_MAX_WS
) (
	input  logic      clk,
	input  logic      arst_n,
	qpd_in_if.sink    in_ch,
	qpd_out_if.source out_ch,
	input  logic      cfg_we,
	input  logic      cfg_wdata
);
	import qpd_pkg::*;

	logic     uas_q;
	qpd_tok_t tok, q_head;
	logic     q_push, q_full, q_pop, q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uas_q <= 1'b0;
		end else if (cfg_we) begin
			uas_q <= cfg_wdata;
		end
	end

	qpd_front #(.MAX_WS(MAX_WS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.tok       (tok),
		.tok_valid (q_push),
		.tok_ready (!q_full)
	);

	qpd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (tok),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_head),
		.empty  (q_empty)
	);

	qpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok       (q_head),
		.tok_valid (!q_empty),
		.tok_pop   (q_pop),
		.uas       (uas_q),
		.out_ch    (out_ch)
	);

	`QPD_ASSERT_IMP(a_q_no_overflow, clk, arst_n, q_full, !(in_ch.valid && in_ch.ready))
	`QPD_ASSERT_IMP(a_q_no_underflow, clk, arst_n, q_pop, !q_empty)
	`QPD_ASSERT_NXT(a_fin_queued, clk, arst_n, q_push && tok.fin, !q_empty)
	`QPD_ASSERT_IMP(a_term_last, clk, arst_n, out_ch.valid && out_ch.out_empty, out_ch.out_last && (out_ch.out_byte == 8'h00))

endmodule

>>> rtl/qpd_front.sv
// Front end: takes input beats, holds space/tab runs and drops those before CR LF.
// Emits escape-stage tokens one per cycle while tok_ready is high. Uses qpd_pkg and qpd_in_if.
module qpd_front #(
	parameter int MAX_WS = qpd_pkg::QPD_MAX_WS
) (
	input  logic              clk,
	input  logic              arst_n,
	qpd_in_if.sink            in_ch,
	output qpd_pkg::qpd_tok_t tok,
	output logic              tok_valid,
	input  logic              tok_ready
);
	import qpd_pkg::*;

	localparam int CW = $clog2(MAX_WS + 1);
	localparam int IW = (MAX_WS > 1) ? $clog2(MAX_WS) : 1;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_WS);
	localparam logic [CW-1:0] ONE_CNT = CW'(1);

	qpd_fstate_t       state_q, state_d;
	logic [CW-1:0]     wc_q, wc_d;
	logic              wcr_q, wcr_d;
	logic              wcom_q, wcom_d;
	logic              mode_b_q, mode_b_d;
	logic [MAX_WS-1:0] kinds_q, kinds_d;
	logic [7:0]        c_q;
	logic              last_q;

	logic [7:0] cur_c;
	logic       cur_last;
	logic       is_ws;
	logic       go;

	assign cur_c    = (state_q == F_ITEM) ? c_q : in_ch.in_byte;
	assign cur_last = (state_q == F_ITEM) ? last_q : in_ch.in_last;
	assign is_ws    = (cur_c == CH_SP) || (cur_c == CH_TAB);

	always_comb begin
		state_d     = state_q;
		wc_d        = wc_q;
		wcr_d       = wcr_q;
		wcom_d      = wcom_q;
		mode_b_d    = mode_b_q;
		kinds_d     = kinds_q;
		tok_valid   = 1'b0;
		tok         = '{ch: cur_c, fin: cur_last};
		in_ch.ready = (state_q == F_IDLE) && tok_ready;
		go          = 1'b0;

		unique case (state_q)
			F_IDLE, F_ITEM: begin
				go = (state_q == F_ITEM) ? tok_ready : (in_ch.valid && tok_ready);
				if (go) begin
					state_d = F_IDLE;
					if (wcr_q) begin
						// run plus CR held: LF drops the run, anything else flushes it
						if (cur_c == CH_LF) begin
							state_d = F_DROP_CR;
						end else begin
							mode_b_d = 1'b0;
							state_d  = F_FLUSH;
						end
					end else if (is_ws) begin
						if (wcom_q) begin
							tok_valid = 1'b1;
							if (cur_last) begin
								wcom_d = 1'b0;
							end
						end else if (wc_q < MAX_CNT) begin
							if (wc_q == '0 && cur_last) begin
								tok_valid = 1'b1;
							end else begin
								kinds_d[wc_q[IW-1:0]] = (cur_c == CH_TAB);
								wc_d = wc_q + ONE_CNT;
								if (cur_last) begin
									mode_b_d = 1'b1;
									state_d  = F_FLUSH;
								end
							end
						end else begin
							// run too long: emit it and pass the rest through
							wcom_d   = 1'b1;
							mode_b_d = 1'b0;
							state_d  = F_FLUSH;
						end
					end else begin
						wcom_d = 1'b0;
						if (cur_c == CH_CR && wc_q != '0) begin
							wcr_d = 1'b1;
							if (cur_last) begin
								mode_b_d = 1'b1;
								state_d  = F_FLUSH;
							end
						end else if (wc_q != '0) begin
							mode_b_d = 1'b0;
							state_d  = F_FLUSH;
						end else begin
							tok_valid = 1'b1;
						end
					end
				end
			end
			F_FLUSH: begin
				tok_valid = 1'b1;
				tok.ch    = kinds_q[0] ? CH_TAB : CH_SP;
				tok.fin   = mode_b_q && !wcr_q && (wc_q == ONE_CNT);
				if (tok_ready) begin
					kinds_d = kinds_q >> 1;
					wc_d    = wc_q - ONE_CNT;
					if (wc_q == ONE_CNT) begin
						if (wcr_q) begin
							state_d = F_FLUSH_CR;
						end else if (mode_b_q) begin
							wcom_d  = 1'b0;
							state_d = F_IDLE;
						end else begin
							state_d = F_ITEM;
						end
					end
				end
			end
			F_FLUSH_CR: begin
				tok_valid = 1'b1;
				tok.ch    = CH_CR;
				tok.fin   = mode_b_q;
				if (tok_ready) begin
					wcr_d = 1'b0;
					if (mode_b_q) begin
						wcom_d  = 1'b0;
						state_d = F_IDLE;
					end else begin
						state_d = F_ITEM;
					end
				end
			end
			F_DROP_CR: begin
				tok_valid = 1'b1;
				tok.ch    = CH_CR;
				tok.fin   = 1'b0;
				if (tok_ready) begin
					state_d = F_DROP_LF;
				end
			end
			F_DROP_LF: begin
				tok_valid = 1'b1;
				tok.ch    = CH_LF;
				tok.fin   = last_q;
				if (tok_ready) begin
					wc_d    = '0;
					wcr_d   = 1'b0;
					state_d = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			wc_q     <= '0;
			wcr_q    <= 1'b0;
			wcom_q   <= 1'b0;
			mode_b_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			wc_q     <= wc_d;
			wcr_q    <= wcr_d;
			wcom_q   <= wcom_d;
			mode_b_q <= mode_b_d;
		end
	end

	always_ff @(posedge clk) begin
		kinds_q <= kinds_d;
		if (in_ch.valid && in_ch.ready) begin
			c_q    <= in_ch.in_byte;
			last_q <= in_ch.in_last;
		end
	end

endmodule

>>> rtl/qpd_fifo.sv
// Token queue between the whitespace front end and the escape back end.
// Uses qpd_pkg for the token type and depth.
module qpd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  qpd_pkg::qpd_tok_t din,
	output logic              full,
	input  logic              pop,
	output qpd_pkg::qpd_tok_t dout,
	output logic              empty
);
	import qpd_pkg::*;

	localparam int PW = $clog2(QPD_Q_DEPTH);
	localparam logic [PW:0] DEPTH_CNT = (PW + 1)'(QPD_Q_DEPTH);
	localparam logic [PW:0] CNT_ONE   = (PW + 1)'(1);
	localparam logic [PW-1:0] PTR_ONE = PW'(1);

	qpd_tok_t      mem_q [QPD_Q_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;
	logic          wr, rd;

	assign full  = (cnt_q == DEPTH_CNT);
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rp_q];
	assign wr    = push && !full;
	assign rd    = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + PTR_ONE;
			end
			if (rd) begin
				rp_q <= rp_q + PTR_ONE;
			end
			unique case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + CNT_ONE;
				2'b01:   cnt_q <= cnt_q - CNT_ONE;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/qpd_back.sv
// Back end: soft line breaks, =XX escapes, underscore-as-space and end-of-text handling.
// Expands each token into up to three result beats. Uses qpd_pkg and qpd_out_if.
module qpd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  qpd_pkg::qpd_tok_t tok,
	input  logic              tok_valid,
	output logic              tok_pop,
	input  logic              uas,
	qpd_out_if.source         out_ch
);
	import qpd_pkg::*;

	localparam int NRES = 3;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic [3:0] hex_nib(input logic [7:0] c);
		logic [7:0] v;
		if (c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c <= 8'h46) begin
			v = c - 8'h37;
		end else begin
			v = c - 8'h57;
		end
		return v[3:0];
	endfunction

	function automatic logic [7:0] txt(input logic [7:0] c, input logic us_sp);
		return (c == CH_US && us_sp) ? CH_SP : c;
	endfunction

	logic       peq_q, pcr_q, phex_q;
	logic [7:0] h_q;
	logic [1:0] k_q;
	logic       out_v_q;
	qpd_res_t   out_res_q;

	qpd_res_t   res [NRES];
	logic [1:0] n;
	logic       np_peq, np_pcr, np_phex;
	logic [7:0] np_h;
	logic       eq_then_c;
	logic       slot_free;
	logic       load;
	logic [7:0] c;

	assign c = tok.ch;

	// results of one token, in order, with the escape state it leaves
	always_comb begin
		for (int i = 0; i < NRES; i++) begin
			res[i] = '0;
		end
		n         = '0;
		np_peq    = peq_q;
		np_pcr    = pcr_q;
		np_phex   = phex_q;
		np_h      = h_q;
		eq_then_c = 1'b0;

		if (!peq_q) begin
			if (c == CH_EQ) begin
				np_peq = 1'b1;
			end else begin
				res[n] = '{data: txt(c, uas), empty: 1'b0, last: 1'b0};
				n = n + 2'd1;
			end
		end else if (pcr_q) begin
			np_peq = 1'b0;
			np_pcr = 1'b0;
			if (c != CH_LF) begin
				res[n] = '{data: CH_EQ, empty: 1'b0, last: 1'b0};
				n = n + 2'd1;
				res[n] = '{data: CH_CR, empty: 1'b0, last: 1'b0};
				n = n + 2'd1;
				eq_then_c = 1'b1;
			end
		end else if (phex_q) begin
			np_peq  = 1'b0;
			np_phex = 1'b0;
			if (is_hex(c)) begin
				res[n] = '{data: {hex_nib(h_q), hex_nib(c)}, empty: 1'b0, last: 1'b0};
				n = n + 2'd1;
			end else begin
				res[n] = '{data: CH_EQ, empty: 1'b0, last: 1'b0};
				n = n + 2'd1;
				res[n] = '{data: txt(h_q, uas), empty: 1'b0, last: 1'b0};
				n = n + 2'd1;
				eq_then_c = 1'b1;
			end
		end else begin
			if (c == CH_CR) begin
				np_pcr = 1'b1;
			end else if (is_hex(c)) begin
				np_phex = 1'b1;
				np_h    = c;
			end else begin
				np_peq = 1'b0;
				res[n] = '{data: CH_EQ, empty: 1'b0, last: 1'b0};
				n = n + 2'd1;
				eq_then_c = 1'b1;
			end
		end

		// the held sequence was given up; the byte starts over
		if (eq_then_c) begin
			if (c == CH_EQ) begin
				np_peq = 1'b1;
			end else begin
				res[n] = '{data: txt(c, uas), empty: 1'b0, last: 1'b0};
				n = n + 2'd1;
			end
		end

		if (tok.fin) begin
			if (np_peq) begin
				res[n] = '{data: CH_EQ, empty: 1'b0, last: 1'b0};
				n = n + 2'd1;
				if (np_pcr) begin
					res[n] = '{data: CH_CR, empty: 1'b0, last: 1'b0};
					n = n + 2'd1;
				end else if (np_phex) begin
					res[n] = '{data: txt(np_h, uas), empty: 1'b0, last: 1'b0};
					n = n + 2'd1;
				end
			end
			np_peq  = 1'b0;
			np_pcr  = 1'b0;
			np_phex = 1'b0;
			if (n == 2'd0) begin
				res[0] = '{data: 8'h00, empty: 1'b1, last: 1'b0};
				n = 2'd1;
			end
			res[n - 2'd1].last = 1'b1;
		end
	end

	assign slot_free = !out_v_q || out_ch.ready;

	always_comb begin
		tok_pop = 1'b0;
		load    = 1'b0;
		if (tok_valid) begin
			if (n == 2'd0) begin
				tok_pop = 1'b1;
			end else if (slot_free) begin
				load = 1'b1;
				if (k_q == n - 2'd1) begin
					tok_pop = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peq_q   <= 1'b0;
			pcr_q   <= 1'b0;
			phex_q  <= 1'b0;
			k_q     <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (tok_pop) begin
				peq_q  <= np_peq;
				pcr_q  <= np_pcr;
				phex_q <= np_phex;
				k_q    <= '0;
			end else if (load) begin
				k_q <= k_q + 2'd1;
			end
			if (load) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_pop) begin
			h_q <= np_h;
		end
		if (load) begin
			out_res_q <= res[k_q];
		end
	end

	assign out_ch.valid     = out_v_q;
	assign out_ch.out_byte  = out_res_q.data;
	assign out_ch.out_empty = out_res_q.empty;
	assign out_ch.out_last  = out_res_q.last;

endmodule
